[sv/hssc_pkg.sv]
// ----------------------------------------------------------------------------
// hssc_pkg
// Types, codes and constants shared by the short string cache modules.
// ----------------------------------------------------------------------------
package hssc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned MAX_BYTES_DEF     = 64;

  localparam logic [31:0] FNV_BASIS     = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME     = 32'h01000193;
  localparam logic [6:0]  COUNT_CAP     = 7'd127;
  localparam logic [6:0]  MAX_LEN_RESET = 7'd64;

  // request codes
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_FILL  = 2'd1;
  localparam logic [1:0] REQ_INVAL = 2'd2;

  // lookup result codes
  localparam logic [1:0] LK_HIT    = 2'd0;
  localparam logic [1:0] LK_MISS   = 2'd1;
  localparam logic [1:0] LK_BYPASS = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] owner_id;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] fill_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  lookup_status;
    logic [31:0] hit_handle;
    logic [31:0] string_hash;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } out_word_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [6:0]  len;
    logic [31:0] owner;
    logic [31:0] handle;
  } entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_CMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_step;
    logic rd_en;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_last_byte;
    logic is_inval;
    logic clr_last;
    logic slot_done;
    logic out_free;
  } status_t;

endpackage

[sv/hashed_short_string_cache_top.sv]
// ----------------------------------------------------------------------------
// hashed_short_string_cache_top
// FNV-1a hashed direct-mapped cache for short strings with owner tags.
// ----------------------------------------------------------------------------
// Non-final byte, fill and ignored words: taken back to back.
// Final byte: slot remainder (mask for a power-of-two table, reciprocal
// remainder otherwise), table read, result load once the output is free;
// next word after that. Invalidate: clears all entries, one entry a cycle.
// Reset (rst_n low, synchronous) starts the same pass; no input word is taken
// until it ends, config writes are taken at any time.
module hashed_short_string_cache_top #(
  parameter int unsigned TABLE_ENTRIES    = hssc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_STRING_BYTES = hssc_pkg::MAX_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hssc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output hssc_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  hssc_pkg::cmd_t    cmd;
  hssc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  hssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hssc_datapath #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .MAX_STRING_BYTES (MAX_STRING_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[sv/hssc_slot_mod.sv]
// ----------------------------------------------------------------------------
// hssc_slot_mod
// Table slot of a 32-bit hash: remainder by TABLE_ENTRIES through a reciprocal
// multiply and a back-multiply, or a plain mask when the table size is a
// power of two.
// ----------------------------------------------------------------------------
module hssc_slot_mod #(
  parameter int unsigned TABLE_ENTRIES = hssc_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned ADDR_W       = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dividend,
  output logic              done,
  output logic [ADDR_W-1:0] rem
);

  localparam bit IsPow2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  // ceil(2^(32+ADDR_W) / TABLE_ENTRIES): (h * RECIP) >> (32+ADDR_W) is exactly h / N
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + ADDR_W)) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));

  logic              mul_r;
  logic              sub_r;
  logic              done_r;
  logic [31:0]       hash_r;
  logic [31:0]       quo_r;
  logic [ADDR_W-1:0] rem_r;
  logic [64:0]       prod;
  logic [31:0]       quo;
  logic [31:0]       back;

  always_comb begin
    prod = {1'b0, 64'(hash_r) * 64'(RECIP[31:0])} +
           (RECIP[32] ? {1'b0, hash_r, 32'd0} : 65'd0);
    quo  = 32'(prod >> (32 + ADDR_W));
    back = 32'(quo_r * 32'(TABLE_ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start && !IsPow2;
      sub_r  <= mul_r;
      done_r <= (start && IsPow2) || sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash_r <= dividend;
    end
    if (mul_r) begin
      quo_r <= quo;
    end
    if (start && IsPow2) begin
      rem_r <= dividend[ADDR_W-1:0];
    end else if (sub_r) begin
      // remainder is below the table size, so the low bits are exact
      rem_r <= hash_r[ADDR_W-1:0] - back[ADDR_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !mul_r && !sub_r && !done_r)
    else $error("slot unit restarted while busy");
`endif

endmodule

[sv/hssc_datapath.sv]
// ----------------------------------------------------------------------------
// hssc_datapath
// Hash folding, entry table, pending fill request, counters, limit register
// and output word register.
// ----------------------------------------------------------------------------
module hssc_datapath #(
  parameter int unsigned TABLE_ENTRIES    = hssc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_STRING_BYTES = hssc_pkg::MAX_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hssc_pkg::in_word_t  in_word,
  output hssc_pkg::out_word_t out_word,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  input  logic [6:0]          cfg_data,
  input  hssc_pkg::cmd_t      cmd,
  output hssc_pkg::status_t   status
);

  localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);

  hssc_pkg::entry_t    mem [TABLE_ENTRIES];
  hssc_pkg::entry_t    rd_r;
  hssc_pkg::entry_t    wr_data;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_en;
  logic                fill_we;

  logic [ADDR_W-1:0]   clr_addr_r;
  logic [31:0]         run_hash_r;
  logic [6:0]          cnt_r;
  logic [31:0]         fin_hash_r;
  logic [6:0]          fin_len_r;
  logic [31:0]         fin_owner_r;
  logic                pend_valid_r;
  logic [31:0]         pend_hash_r;
  logic [6:0]          pend_len_r;
  logic [31:0]         pend_owner_r;
  logic [ADDR_W-1:0]   pend_slot_r;
  logic [31:0]         hit_cnt_r;
  logic [31:0]         miss_cnt_r;
  logic [6:0]          max_len_r;
  hssc_pkg::out_word_t out_r;
  logic                out_valid_r;

  logic                is_byte;
  logic [31:0]         hash_nxt;
  logic [6:0]          cnt_nxt;
  logic [6:0]          limit;
  logic                bypass;
  logic                hit;
  logic                slot_done;
  logic [ADDR_W-1:0]   slot;

  hssc_slot_mod #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_slot (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.accept && is_byte && in_word.last_byte),
    .dividend (hash_nxt),
    .done     (slot_done),
    .rem      (slot)
  );

  always_comb begin
    is_byte  = in_word.req_type == hssc_pkg::REQ_BYTE;
    hash_nxt = 32'((run_hash_r ^ {24'd0, in_word.data_byte}) * hssc_pkg::FNV_PRIME);
    cnt_nxt  = (cnt_r == hssc_pkg::COUNT_CAP) ? cnt_r : cnt_r + 7'd1;
    limit    = (max_len_r > 7'(MAX_STRING_BYTES)) ? 7'(MAX_STRING_BYTES) : max_len_r;
    bypass   = (fin_len_r > limit) || (fin_owner_r == 32'd0);
    hit      = !bypass && rd_r.owner == fin_owner_r && rd_r.hash == fin_hash_r &&
               rd_r.len == fin_len_r && rd_r.handle != 32'd0;
    fill_we  = cmd.accept && in_word.req_type == hssc_pkg::REQ_FILL && pend_valid_r;
    wr_en    = cmd.clr_step || fill_we;
    wr_addr  = cmd.clr_step ? clr_addr_r : pend_slot_r;
    wr_data  = cmd.clr_step ? '0 :
               {pend_hash_r, pend_len_r, pend_owner_r, in_word.fill_handle};
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= status.clr_last ? '0 : clr_addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_hash_r <= hssc_pkg::FNV_BASIS;
      cnt_r      <= '0;
    end else if (cmd.accept && is_byte) begin
      if (in_word.last_byte) begin
        run_hash_r <= hssc_pkg::FNV_BASIS;
        cnt_r      <= '0;
      end else begin
        run_hash_r <= hash_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_byte && in_word.last_byte) begin
      fin_hash_r  <= hash_nxt;
      fin_len_r   <= cnt_nxt;
      fin_owner_r <= in_word.owner_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
    end else if (cmd.load_out) begin
      pend_valid_r <= !bypass && !hit;
      if (hit) begin
        hit_cnt_r <= hit_cnt_r + 32'd1;
      end else if (!bypass) begin
        miss_cnt_r <= miss_cnt_r + 32'd1;
      end
    end else if (cmd.accept && (fill_we || in_word.req_type == hssc_pkg::REQ_INVAL)) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out && !bypass && !hit) begin
      pend_hash_r  <= fin_hash_r;
      pend_len_r   <= fin_len_r;
      pend_owner_r <= fin_owner_r;
      pend_slot_r  <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= hssc_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.lookup_status <= bypass ? hssc_pkg::LK_BYPASS :
                             hit    ? hssc_pkg::LK_HIT : hssc_pkg::LK_MISS;
      out_r.hit_handle    <= hit ? rd_r.handle : 32'd0;
      out_r.string_hash   <= fin_hash_r;
      out_r.hit_total     <= hit ? hit_cnt_r + 32'd1 : hit_cnt_r;
      out_r.miss_total    <= (!bypass && !hit) ? miss_cnt_r + 32'd1 : miss_cnt_r;
    end
  end

  always_comb begin
    status.is_last_byte = is_byte && in_word.last_byte;
    status.is_inval     = in_word.req_type == hssc_pkg::REQ_INVAL;
    status.clr_last     = clr_addr_r == ADDR_W'(TABLE_ENTRIES - 1);
    status.slot_done    = slot_done;
    status.out_free     = !out_valid_r || out_ready;
  end

  assign out_word  = out_r;
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid_r || out_ready)
    else $error("output word overwritten while stalled");
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_step && fill_we))
    else $error("fill write during clearing pass");
  a_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load_out |=> $stable(hit_cnt_r) && $stable(miss_cnt_r))
    else $error("counter moved without a lookup result");
`endif

endmodule

[sv/hssc_ctrl.sv]
// ----------------------------------------------------------------------------
// hssc_ctrl
// Sequencer: clearing pass, item intake, slot wait and result load.
// ----------------------------------------------------------------------------
module hssc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hssc_pkg::status_t status,
  output hssc_pkg::cmd_t    cmd
);

  hssc_pkg::state_t state_r;
  hssc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hssc_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hssc_pkg::S_CLEAR: begin
        if (status.clr_last) state_nxt = hssc_pkg::S_IDLE;
      end
      hssc_pkg::S_IDLE: begin
        if (in_valid) begin
          if (status.is_inval) state_nxt = hssc_pkg::S_CLEAR;
          else if (status.is_last_byte) state_nxt = hssc_pkg::S_SLOT;
        end
      end
      hssc_pkg::S_SLOT: begin
        if (status.slot_done) state_nxt = hssc_pkg::S_CMP;
      end
      hssc_pkg::S_CMP: begin
        if (status.out_free) state_nxt = hssc_pkg::S_IDLE;
      end
      default: state_nxt = hssc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready     = state_r == hssc_pkg::S_IDLE;
    cmd.accept   = in_ready && in_valid;
    cmd.clr_step = state_r == hssc_pkg::S_CLEAR;
    cmd.rd_en    = state_r == hssc_pkg::S_SLOT && status.slot_done;
    cmd.load_out = state_r == hssc_pkg::S_CMP && status.out_free;
  end

`ifndef NO_ASSERTIONS
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.slot_done |-> state_r == hssc_pkg::S_SLOT)
    else $error("slot result arrived outside the slot wait");
`endif

endmodule
